>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the post request match table.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/prmt_pkg.sv
// Types, sizes and helper functions of the post request match table.
// Used by every module of the block; depends on nothing.
package prmt_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_BITS = 16;
  localparam int TAG_BITS = 16;
  localparam int IN_KEY_W = 16;
  localparam int IN_TAG_W = 16;
  localparam int OUT_CNT_W = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_NODE_TAG = 2'd1,
    KIND_NODE     = 2'd2,
    KIND_ANY      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [IN_KEY_W-1:0]  node_key;
    logic [IN_TAG_W-1:0]  tag;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_CNT_W-1:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic cmp_en;
    logic chk_tag;
    logic add_en;
  } cell_ctl_t;

  function automatic key_t fit_key(logic [IN_KEY_W-1:0] k);
    logic [KEY_BITS+IN_KEY_W-1:0] w;
    w = {{KEY_BITS{1'b0}}, k};
    return w[KEY_BITS-1:0];
  endfunction

  function automatic tag_t fit_tag(logic [IN_TAG_W-1:0] t);
    logic [TAG_BITS+IN_TAG_W-1:0] w;
    w = {{TAG_BITS{1'b0}}, t};
    return w[TAG_BITS-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] to_out_count(cnt_t c);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, c};
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/prmt_cell.sv
// One slot of the match table: a stored key and tag, its compare and its shift.
// Depends on prmt_pkg.
module prmt_cell (
  input  logic                clk,
  input  logic                rst,
  input  prmt_pkg::cnt_t      slot,
  input  prmt_pkg::cnt_t      count,
  input  prmt_pkg::cell_ctl_t ctl,
  input  prmt_pkg::key_t      req_key,
  input  prmt_pkg::tag_t      req_tag,
  input  logic                shift_en,
  input  prmt_pkg::key_t      nb_key,
  input  prmt_pkg::tag_t      nb_tag,
  output prmt_pkg::key_t      key,
  output prmt_pkg::tag_t      tag,
  output logic                match
);
  import prmt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.add_en && (slot == count)) begin
      key <= req_key;
      tag <= req_tag;
    end else if (shift_en) begin
      key <= nb_key;
      tag <= nb_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp_en) begin
      match <= (slot < count) && (key == req_key) && (!ctl.chk_tag || (tag == req_tag));
    end
  end

endmodule

>>> hw/rtl/prmt_select.sv
// Picks the newest matching slot and forms the shift mask that closes the gap.
// Depends on prmt_pkg.
module prmt_select (
  input  logic [prmt_pkg::DEPTH-1:0] match,
  input  prmt_pkg::cnt_t             count,
  output logic                       hit,
  output logic [prmt_pkg::DEPTH-1:0] shift_en
);
  import prmt_pkg::*;

  assign hit = |match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_mask
    assign shift_en[i] = hit && !(|(match >> (i + 1))) && (CNT_W'(i + 1) < count);
  end

endmodule

>>> hw/rtl/post_request_match_table_unit.sv
// Post request match table: an ordered row of cells holding node keys and tags,
// oldest entry in the lowest cell. Depends on prmt_pkg, prmt_cell, prmt_select
// and assert_macros.svh.
//
// A request passes the accept cycle, a compare state in which all cells compare
// their entry at once, and an apply state in which an add writes the new entry or
// a node match shifts the table down over the removed entry; done rises in the
// cycle after that and busy falls with it, so requests do not overlap. done is
// high for one cycle only and cannot be held off. Stored entries have no reset;
// the held count clears on reset and decides which cells take part in a compare.
`include "assert_macros.svh"

module post_request_match_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  prmt_pkg::req_t     req,
  output logic               done,
  output prmt_pkg::result_t  result
);
  import prmt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CMP   = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t    state;
  state_t    state_next;
  kind_t     kind;
  key_t      req_key;
  tag_t      req_tag;
  cnt_t      count;
  cnt_t      count_next;
  status_t   status_next;
  cell_ctl_t ctl;
  logic      hit;
  logic      is_match_kind;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] shift_mask;
  logic [DEPTH-1:0] shift_en;
  key_t      keys [DEPTH];
  tag_t      tags [DEPTH];

  assign busy = (state != ST_IDLE);
  assign is_match_kind = (kind == KIND_NODE_TAG) || (kind == KIND_NODE);

  always_comb begin
    ctl.cmp_en  = (state == ST_CMP);
    ctl.chk_tag = (kind == KIND_NODE_TAG);
    ctl.add_en  = (state == ST_APPLY) && (kind == KIND_ADD) && (count != CNT_W'(DEPTH));
  end

  assign shift_en = (state == ST_APPLY) && is_match_kind ? shift_mask : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    prmt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot     (CNT_W'(i)),
      .count    (count),
      .ctl      (ctl),
      .req_key  (req_key),
      .req_tag  (req_tag),
      .shift_en (shift_en[i]),
      .nb_key   ((i + 1 < DEPTH) ? keys[(i + 1) % DEPTH] : key_t'(0)),
      .nb_tag   ((i + 1 < DEPTH) ? tags[(i + 1) % DEPTH] : tag_t'(0)),
      .key      (keys[i]),
      .tag      (tags[i]),
      .match    (match[i])
    );
  end

  prmt_select u_select (
    .match    (match),
    .count    (count),
    .hit      (hit),
    .shift_en (shift_mask)
  );

  always_comb begin
    count_next  = count;
    status_next = STATUS_DONE;
    case (kind)
      KIND_ADD: begin
        if (count == CNT_W'(DEPTH)) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      KIND_NODE_TAG, KIND_NODE: begin
        if (hit) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = STATUS_MISS;
        end
      end
      KIND_ANY: begin
        if (count != '0) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = STATUS_MISS;
        end
      end
      default: begin
        status_next = STATUS_MISS;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE:  state_next = (start) ? ST_CMP : ST_IDLE;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_APPLY);
      if (state == ST_APPLY) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind    <= req.kind;
      req_key <= fit_key(req.node_key);
      req_tag <= fit_tag(req.tag);
    end
    if (state == ST_APPLY) begin
      result.status      <= status_next;
      result.entry_count <= to_out_count(count_next);
    end
  end

  `ASSERT_IMPLY(a_count_range, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_done_latency, clk, rst, done, $past(start && !busy, 3))
  `ASSERT_IMPLY(a_full_count, clk, rst, done && result.status == STATUS_FULL, count == CNT_W'(DEPTH))
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule
